FILE: src/tsrg_pkg.sv
//------------------------------------------------------------------------------
// tsrg_pkg
// Types and constants shared by the trimmed step-rate generator.
//------------------------------------------------------------------------------
package tsrg_pkg;

  typedef struct packed {
    logic       kind;
    logic [9:0] pot_sample;
    logic       tracking_switch;
    logic       direction_switch;
  } in_item_t;

  typedef struct packed {
    logic        step_pulse;
    logic        dir_level;
    logic        enable_n;
    logic [31:0] step_interval_us;
    logic [16:0] smoothed_trim_q16;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base_rate_q16;
    logic [9:0]  pot_center;
    logic [8:0]  deadband;
    logic [16:0] ema_alpha_q16;
    logic        dir_left_forward;
    logic [15:0] dir_holdoff_us;
    logic [15:0] dir_accept_ms;
  } cfg_t;

  localparam logic [2:0] REG_BASE_RATE = 3'd0;
  localparam logic [2:0] REG_POT_CENTER = 3'd1;
  localparam logic [2:0] REG_DEADBAND = 3'd2;
  localparam logic [2:0] REG_EMA_ALPHA = 3'd3;
  localparam logic [2:0] REG_DIR_LEFT_FWD = 3'd4;
  localparam logic [2:0] REG_DIR_HOLDOFF = 3'd5;
  localparam logic [2:0] REG_DIR_ACCEPT = 3'd6;

  localparam logic [31:0] INTERVAL_RESET = 32'd1000000;
  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [63:0] INTERVAL_NUM = 64'd1000000 << 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_EMA,
    ST_MUL,
    ST_IDIV,
    ST_DONE
  } trim_state_t;

endpackage

FILE: src/tsrg_queue.sv
//------------------------------------------------------------------------------
// tsrg_queue
// Small register queue that carries items between the two halves.
//------------------------------------------------------------------------------
module tsrg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd && !empty) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

FILE: src/tsrg_trim.sv
//------------------------------------------------------------------------------
// tsrg_trim
// Turns a completed pot sum into the smoothed trim and the step interval.
// The trim comes from a reciprocal multiply, low part and then high part, and the
// interval from a 64-step serial division.
//------------------------------------------------------------------------------
module tsrg_trim #(
  parameter int AVG_SAMPLES = 8,
  parameter int SUM_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tsrg_pkg::cfg_t      cfg,
  input  logic                start,
  input  logic [SUM_W-1:0]    sum,
  output logic                busy,
  output logic [16:0]         trim_smoothed,
  output logic [31:0]         interval_us
);
  import tsrg_pkg::*;

  localparam logic [31:0] DEN = 32'(5 * AVG_SAMPLES * 1023);
  localparam logic [31:0] BIAS = 32'(4 * AVG_SAMPLES * 1023);
  localparam logic [63:0] NUM_MAX = (64'd65536 * 64'(6 * AVG_SAMPLES * 1023)) +
                                    64'(DEN >> 1);
  localparam int NW = $clog2(NUM_MAX + 64'd1);
  localparam int RW = NW + 1;
  localparam int KSH = NW + $clog2(DEN);
  localparam logic [63:0] RECIP = ((64'd1 << KSH) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [17:0] RECIP_LO = RECIP[17:0];
  localparam logic [RW-19:0] RECIP_HI = RECIP[RW-1:18];
  localparam logic [63:0] RATE_FLOOR_P = (64'h1_0000_0000 + 64'd9999) / 64'd10000;

  trim_state_t state;
  trim_state_t state_next;
  logic        trim_valid;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [16:0] trim_new;
  logic [63:0] prod;

  logic signed [19:0] lo;
  logic signed [19:0] hi;
  logic signed [19:0] ssum;
  logic [31:0] s_eff;
  logic [63:0] num;
  logic [NW+17:0] plo;
  logic [NW+RW-1:0] pfull;
  logic [16:0] alpha;
  logic signed [18:0] diff;
  logic signed [37:0] eprod;
  logic signed [37:0] ed;
  logic [16:0] trim_base;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  assign busy = (state != ST_IDLE);
  assign lo   = (20'(cfg.pot_center) - 20'(cfg.deadband)) * 20'(AVG_SAMPLES);
  assign hi   = (20'(cfg.pot_center) + 20'(cfg.deadband)) * 20'(AVG_SAMPLES);
  assign ssum = 20'(sum);
  assign s_eff = (ssum > lo && ssum < hi) ? 32'(cfg.pot_center) * 32'(AVG_SAMPLES)
                                          : 32'(sum);
  assign num  = ((64'(BIAS) + (64'(s_eff) << 1)) << 16) + 64'(DEN >> 1);
  assign pfull = (NW+RW)'(plo) + ((NW+RW)'(num[NW-1:0] * RECIP_HI) << 18);
  assign alpha = (cfg.ema_alpha_q16 > 17'd65536) ? 17'd65536 : cfg.ema_alpha_q16;
  assign trim_base = trim_valid ? trim_smoothed : trim_new;
  assign diff = 19'(trim_new) - 19'(trim_base);
  assign eprod = $signed({21'd0, alpha}) * 38'(diff) + 38'sd32768;
  assign ed = eprod >>> 16;
  assign rem_sh = {rem, quo[63]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_TDIV;
      ST_TDIV: if (cnt == 7'd1) state_next = ST_EMA;
      ST_EMA:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_IDIV;
      ST_IDIV: if (cnt == 7'd63) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_valid    <= 1'b0;
      trim_smoothed <= '0;
      interval_us   <= INTERVAL_RESET;
      cnt           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_TDIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 7'd0) begin
            plo <= num[NW-1:0] * RECIP_LO;
          end else begin
            trim_new <= 17'(pfull >> KSH);
          end
        end
        ST_IDIV: begin
          cnt <= cnt + 1'b1;
          if (!rem_sub[64]) begin
            rem <= rem_sub[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        ST_EMA: begin
          trim_smoothed <= 17'(38'(trim_base) + ed);
          trim_valid    <= 1'b1;
        end
        ST_MUL: begin
          prod <= 64'(cfg.base_rate_q16) * 64'(trim_smoothed);
          cnt  <= '0;
          rem  <= '0;
          quo  <= INTERVAL_NUM;
        end
        ST_DONE: begin
          if (prod < RATE_FLOOR_P || quo[63:32] != '0) begin
            interval_us <= 32'hFFFF_FFFF;
          end else begin
            interval_us <= quo[31:0];
          end
        end
        default: ;
      endcase
      if (state == ST_MUL) begin
        dvs <= 64'(cfg.base_rate_q16) * 64'(trim_smoothed);
      end
    end
  end

endmodule

FILE: src/tsrg_front.sv
//------------------------------------------------------------------------------
// tsrg_front
// Keeps the pot accumulator for accepted items and flags the sample that completes an average.
//------------------------------------------------------------------------------
module tsrg_front #(
  parameter int AVG_SAMPLES = 8,
  parameter int SUM_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  tsrg_pkg::in_item_t item,
  input  logic               take,
  output logic               avg_done,
  output logic [SUM_W-1:0]   avg_sum
);
  import tsrg_pkg::*;

  localparam int CW = $clog2(AVG_SAMPLES + 1);

  logic [SUM_W-1:0] pot_sum;
  logic [CW-1:0]    pot_count;
  logic [SUM_W-1:0] sum_next;

  assign sum_next = pot_sum + SUM_W'(item.pot_sample);
  assign avg_done = take && item.kind && (pot_count == CW'(AVG_SAMPLES - 1));
  assign avg_sum  = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_sum   <= '0;
      pot_count <= '0;
    end else if (take && item.kind) begin
      if (avg_done) begin
        pot_sum   <= '0;
        pot_count <= '0;
      end else begin
        pot_sum   <= sum_next;
        pot_count <= pot_count + 1'b1;
      end
    end
  end

endmodule

FILE: src/tsrg_back.sv
//------------------------------------------------------------------------------
// tsrg_back
// Time base, direction acceptance and step decision for one queued item.
//------------------------------------------------------------------------------
module tsrg_back (
  input  logic                clk,
  input  logic                rst,
  input  tsrg_pkg::cfg_t      cfg,
  input  tsrg_pkg::in_item_t  item,
  input  logic                go,
  input  logic [31:0]         interval_us,
  input  logic [16:0]         trim_q16,
  output tsrg_pkg::out_item_t result
);
  import tsrg_pkg::*;

  logic [31:0] time_us;
  logic [9:0]  ms_prescale;
  logic [31:0] time_ms;
  logic [31:0] last_step_us;
  logic        accepted_forward;
  logic [31:0] last_dir_change_ms;
  logic [31:0] dir_changed_us;

  logic        tick;
  logic        forward;
  logic [31:0] t_us;
  logic [9:0]  pre_inc;
  logic [31:0] t_ms;
  logic        acc;
  logic [31:0] dchg;
  logic [31:0] since;
  logic        hold;
  logic        step;
  logic [31:0] ls_adv;

  always_comb begin
    tick    = !item.kind;
    forward = cfg.dir_left_forward ? item.direction_switch : !item.direction_switch;
    t_us    = tick ? time_us + 32'd1 : time_us;
    pre_inc = ms_prescale + 10'd1;
    t_ms    = (tick && pre_inc >= US_PER_MS) ? time_ms + 32'd1 : time_ms;
    acc     = (forward != accepted_forward) &&
              ((t_ms - last_dir_change_ms) >= 32'(cfg.dir_accept_ms));
    dchg    = acc ? t_us : dir_changed_us;
    since   = t_us - dchg;
    hold    = since[31] || (since < 32'(cfg.dir_holdoff_us));
    step    = tick && item.tracking_switch && !hold &&
              ((t_us - last_step_us) >= interval_us);
    ls_adv  = last_step_us + interval_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_us <= '0;
      ms_prescale <= '0;
      time_ms <= '0;
      last_step_us <= '0;
      accepted_forward <= 1'b0;
      last_dir_change_ms <= '0;
      dir_changed_us <= '0;
    end else if (go) begin
      time_us <= t_us;
      time_ms <= t_ms;
      if (tick) begin
        ms_prescale <= (pre_inc >= US_PER_MS) ? '0 : pre_inc;
      end
      if (acc) begin
        accepted_forward <= forward;
        last_dir_change_ms <= t_ms;
        dir_changed_us <= t_us;
      end
      if (step) begin
        last_step_us <= ((t_us - ls_adv) >= interval_us) ? t_us : ls_adv;
      end
    end
  end

  always_comb begin
    result.step_pulse        = step;
    result.dir_level         = forward;
    result.enable_n          = !item.tracking_switch;
    result.step_interval_us  = interval_us;
    result.smoothed_trim_q16 = trim_q16;
  end

endmodule

FILE: src/trimmed_step_rate_generator_core.sv
//------------------------------------------------------------------------------
// trimmed_step_rate_generator_core
// Step-rate generator with potentiometer trim, direction holdoff and queues.
//------------------------------------------------------------------------------
// Ticks and pot samples are taken one per cycle, while there is room, into a
// four-entry queue. An item that does not complete an average leaves the queue
// once it is at the head and the result queue has room, and its result can be
// popped from the cycle after that. The pot sample that completes an average
// starts the trim unit when it reaches the head of the queue and stays there
// while the trim unit takes a start, the reciprocal multiply for the trim, the
// smoothing, the rate product, a 64-step serial division for the interval and
// the storing of it, and then hands the item on. Later items queue up behind
// it, and the input stalls once the four-entry queue is full.
module trimmed_step_rate_generator_core #(
  parameter int AVG_SAMPLES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tsrg_pkg::in_item_t   in_item,
  output logic                 empty,
  input  logic                 pop,
  output tsrg_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import tsrg_pkg::*;

  localparam int SUM_W = $clog2(AVG_SAMPLES * 1023 + 1);
  localparam int QW = $bits(in_item_t) + 1 + SUM_W;

  cfg_t cfg;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic q_empty;
  logic q_rd;
  logic avg_done;
  logic [SUM_W-1:0] avg_sum;
  in_item_t q_item;
  logic q_avg;
  logic [SUM_W-1:0] q_sum;
  logic trim_busy;
  logic [16:0] trim_smoothed;
  logic [31:0] interval_us;
  logic started;
  logic o_full;
  out_item_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_rate_q16 <= 32'd638710;
      cfg.pot_center <= 10'd512;
      cfg.deadband <= 9'd8;
      cfg.ema_alpha_q16 <= 17'd13107;
      cfg.dir_left_forward <= 1'b1;
      cfg.dir_holdoff_us <= 16'd500;
      cfg.dir_accept_ms <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_RATE:    cfg.base_rate_q16 <= cfg_data;
        REG_POT_CENTER:   cfg.pot_center <= cfg_data[9:0];
        REG_DEADBAND:     cfg.deadband <= cfg_data[8:0];
        REG_EMA_ALPHA:    cfg.ema_alpha_q16 <= cfg_data[16:0];
        REG_DIR_LEFT_FWD: cfg.dir_left_forward <= cfg_data[0];
        REG_DIR_HOLDOFF:  cfg.dir_holdoff_us <= cfg_data[15:0];
        REG_DIR_ACCEPT:   cfg.dir_accept_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tsrg_front #(.AVG_SAMPLES(AVG_SAMPLES), .SUM_W(SUM_W)) u_front (
    .clk(clk), .rst(rst), .item(in_item), .take(push && !full),
    .avg_done(avg_done), .avg_sum(avg_sum)
  );

  assign q_wdata = {in_item, avg_done, avg_sum};

  tsrg_queue #(.WIDTH(QW), .DEPTH(4)) u_inq (
    .clk(clk), .rst(rst), .wr(push), .wdata(q_wdata), .full(full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  assign {q_item, q_avg, q_sum} = q_rdata;

  // An averaging item first starts the trim unit, then leaves once it is idle and the result queue has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (q_rd) begin
      started <= 1'b0;
    end else if (!q_empty && q_avg && !started) begin
      started <= 1'b1;
    end
  end

  assign q_rd = !q_empty && !o_full && (!q_avg || (started && !trim_busy));

  tsrg_trim #(.AVG_SAMPLES(AVG_SAMPLES), .SUM_W(SUM_W)) u_trim (
    .clk(clk), .rst(rst), .cfg(cfg),
    .start(!q_empty && q_avg && !started), .sum(q_sum),
    .busy(trim_busy), .trim_smoothed(trim_smoothed), .interval_us(interval_us)
  );

  tsrg_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .item(q_item), .go(q_rd),
    .interval_us(interval_us), .trim_q16(trim_smoothed), .result(res)
  );

  tsrg_queue #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_outq (
    .clk(clk), .rst(rst), .wr(q_rd), .wdata(res), .full(o_full),
    .rd(pop), .rdata(out_item), .empty(empty)
  );

endmodule

FILE: src/tsrg_checker.sv
//------------------------------------------------------------------------------
// tsrg_checker
// Port-level checks for the step-rate generator.
//------------------------------------------------------------------------------
module tsrg_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input tsrg_pkg::out_item_t out_item
);
  import tsrg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_item))
    else $error("result changed while waiting");

  a_enable_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.step_pulse) |-> !out_item.enable_n)
    else $error("step while tracking off");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not clear after reset");

endmodule

bind trimmed_step_rate_generator_core tsrg_port_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);

FILE: tb/sv/tsrg_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tsrg_checker
// Watches the item, result and register channels of the step-rate generator.
// It keeps its own copy of the trim, timing and direction state, and works out
// the expected result of every item that is transferred in. It then compares
// each result that is transferred out, as a whole, with the oldest
// expected result.
//------------------------------------------------------------------------------
module tsrg_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  tsrg_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  tsrg_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  steps
);
  import tsrg_pkg::*;

  cfg_t        regs;
  logic [31:0] pot_sum;
  int          pot_count;
  logic [16:0] trim_q16;
  logic        have_trim;
  logic [31:0] interval, now_us, last_step, dir_at_us, now_ms, dir_at_ms;
  logic [9:0]  ms_div;
  logic        fwd_state;
  out_item_t   expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [16:0] trim_of_sum(logic [31:0] sum);
    longint lo, hi, s, num;
    lo = (longint'(regs.pot_center) - longint'(regs.deadband)) * 8;
    hi = (longint'(regs.pot_center) + longint'(regs.deadband)) * 8;
    s = longint'(sum);
    if (s > lo && s < hi) begin
      s = longint'(regs.pot_center) * 8;
    end
    num = 65536 * (4 * 8 * 1023 + 2 * s);
    return 17'((num + 20460) / 40920);
  endfunction

  task automatic finish_average(logic [31:0] sum);
    logic [16:0]     t;
    longint          a, prod, d;
    longint unsigned p, q;
    t = trim_of_sum(sum);
    a = (regs.ema_alpha_q16 > 17'd65536) ? 65536 : longint'(regs.ema_alpha_q16);
    if (!have_trim) begin
      trim_q16 = t;
      have_trim = 1'b1;
    end
    prod = a * (longint'(t) - longint'(trim_q16)) + 32768;
    if (prod >= 0) begin
      d = prod / 65536;
    end else begin
      d = -((-prod + 65535) / 65536);
    end
    trim_q16 = 17'(longint'(trim_q16) + d);
    p = longint'(regs.base_rate_q16) * longint'(trim_q16);
    if (p * 10000 < 64'h1_0000_0000) begin
      interval = 32'hFFFF_FFFF;
    end else begin
      q = (64'd1000000 << 32) / p;
      interval = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
  endtask

  task automatic predict(in_item_t it, output out_item_t res);
    logic        tick, fwd, step;
    logic [31:0] since;
    tick = (it.kind == 1'b0);
    fwd = regs.dir_left_forward ? it.direction_switch : !it.direction_switch;
    step = 1'b0;
    if (tick) begin
      now_us = now_us + 32'd1;
      ms_div = ms_div + 10'd1;
      if (ms_div >= US_PER_MS) begin
        ms_div = '0;
        now_ms = now_ms + 32'd1;
      end
    end else begin
      pot_sum = pot_sum + 32'(it.pot_sample);
      pot_count++;
      if (pot_count >= 8) begin
        pot_count = 0;
        finish_average(pot_sum);
        pot_sum = '0;
      end
    end
    if (fwd != fwd_state && (now_ms - dir_at_ms) >= regs.dir_accept_ms) begin
      fwd_state = fwd;
      dir_at_ms = now_ms;
      dir_at_us = now_us;
    end
    if (tick && it.tracking_switch) begin
      since = now_us - dir_at_us;
      if (!(since[31] || since < regs.dir_holdoff_us) && (now_us - last_step) >= interval) begin
        step = 1'b1;
        last_step = last_step + interval;
        if ((now_us - last_step) >= interval) begin
          last_step = now_us;
        end
      end
    end
    res.step_pulse = step;
    res.dir_level = fwd;
    res.enable_n = !it.tracking_switch;
    res.step_interval_us = interval;
    res.smoothed_trim_q16 = trim_q16;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      regs.base_rate_q16 = 32'd638710;
      regs.pot_center = 10'd512;
      regs.deadband = 9'd8;
      regs.ema_alpha_q16 = 17'd13107;
      regs.dir_left_forward = 1'b1;
      regs.dir_holdoff_us = 16'd500;
      regs.dir_accept_ms = 16'd2000;
      pot_sum = '0;
      pot_count = 0;
      trim_q16 = '0;
      have_trim = 1'b0;
      interval = INTERVAL_RESET;
      now_us = '0;
      ms_div = '0;
      now_ms = '0;
      last_step = '0;
      fwd_state = 1'b0;
      dir_at_ms = '0;
      dir_at_us = '0;
      expected_results.delete();
      errors = 0;
      steps = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_RATE:    regs.base_rate_q16 = cfg_data;
          REG_POT_CENTER:   regs.pot_center = cfg_data[9:0];
          REG_DEADBAND:     regs.deadband = cfg_data[8:0];
          REG_EMA_ALPHA:    regs.ema_alpha_q16 = cfg_data[16:0];
          REG_DIR_LEFT_FWD: regs.dir_left_forward = cfg_data[0];
          REG_DIR_HOLDOFF:  regs.dir_holdoff_us = cfg_data[15:0];
          REG_DIR_ACCEPT:   regs.dir_accept_ms = cfg_data[15:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        predict(in_item, e);
        expected_results.push_back(e);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p", $time, out_item);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_item.step_pulse) steps++;
          if (out_item !== e) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_item);
            errors++;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Stimulus for the trimmed step-rate generator.
// Drives ticks and pot samples with random gaps and result stalls, one long
// receiver stall, and several register settings including the extremes. The
// checker predicts and compares; this module gives the verdict.
//------------------------------------------------------------------------------
module tb;
  import tsrg_pkg::*;

  logic        clk, rst, push, full, empty, pop, cfg_valid, cfg_ready;
  in_item_t    in_item;
  out_item_t   out_item;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending, steps, items;
  logic        quiet, hold_req, dir_lvl, trk;
  cfg_t        cur;

  trimmed_step_rate_generator_core dut (.*);

  tsrg_checker chk (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      pop <= quiet || ($urandom_range(0, 99) >= 14);
    end
  end

  task automatic send(in_item_t it);
    logic took;
    while (!quiet && $urandom_range(0, 99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      took = !full;
      @(posedge clk);
    end while (!took);
    items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic apply_cfg();
    write_reg(REG_BASE_RATE, cur.base_rate_q16);
    write_reg(REG_POT_CENTER, 32'(cur.pot_center));
    write_reg(REG_DEADBAND, 32'(cur.deadband));
    write_reg(REG_EMA_ALPHA, 32'(cur.ema_alpha_q16));
    write_reg(REG_DIR_LEFT_FWD, 32'(cur.dir_left_forward));
    write_reg(REG_DIR_HOLDOFF, 32'(cur.dir_holdoff_us));
    write_reg(REG_DIR_ACCEPT, 32'(cur.dir_accept_ms));
  endtask

  function automatic in_item_t make_item(logic k, int sample, logic t, logic d);
    in_item_t it;
    it.kind = k;
    it.pot_sample = 10'(sample);
    it.tracking_switch = t;
    it.direction_switch = d;
    return it;
  endfunction

  function automatic int pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(cur.pot_center);
      1: v = int'(cur.pot_center) + int'(cur.deadband) - 1 + int'($urandom_range(0, 2));
      2: v = int'(cur.pot_center) - int'(cur.deadband) - 1 + int'($urandom_range(0, 2));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    dir_lvl = 1'b0;
    trk = 1'b1;
    items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Trim extremes, switches, and a mean just inside the deadband edge at reset settings.
    send(make_item(1'b0, 0, 1'b0, 1'b0));
    send(make_item(1'b0, 1023, 1'b1, 1'b1));
    send(make_item(1'b0, 0, 1'b1, 1'b0));
    repeat (8) send(make_item(1'b1, 0, 1'b1, 1'b1));
    repeat (8) send(make_item(1'b1, 1023, 1'b0, 1'b0));
    repeat (4) send(make_item(1'b1, 520, 1'b1, 1'b1));
    repeat (4) send(make_item(1'b1, 519, 1'b1, 1'b1));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cur = '{32'hFFFF_FFFF, 10'd512, 9'd8, 17'd13107, 1'b1, 16'd20, 16'd0};
        1: cur = '{32'd0, 10'd0, 9'd0, 17'd0, 1'b0, 16'd0, 16'd65535};
        2: cur = '{32'h8000_0000, 10'd1023, 9'd511, 17'd65536, 1'b1, 16'd65535, 16'd1};
        3: cur = '{32'd1500000000, 10'd300, 9'd40, 17'h1FFFF, 1'b0, 16'd5, 16'd0};
        default: begin
          cur.base_rate_q16 = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
          cur.pot_center = 10'($urandom_range(0, 1023));
          cur.deadband = 9'($urandom_range(0, 60));
          cur.ema_alpha_q16 = 17'($urandom_range(0, 17'h1FFFF));
          cur.dir_left_forward = 1'($urandom_range(0, 1));
          cur.dir_holdoff_us = 16'($urandom_range(0, 30));
          cur.dir_accept_ms = 16'($urandom_range(0, 1));
        end
      endcase
      apply_cfg();
      quiet = (ph == 3);
      hold_req = (ph == 0);
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(0, 99) < 3) dir_lvl = !dir_lvl;
        trk = ($urandom_range(0, 99) < 90);
        if ($urandom_range(0, 99) < 15) begin
          send(make_item(1'b1, pick_sample(), trk, dir_lvl));
        end else begin
          send(make_item(1'b0, $urandom_range(0, 1023), trk, dir_lvl));
        end
      end
      quiet = 1'b0;
      settle();
    end

    $display("Sent %0d items over six register settings; %0d step pulses came out.",
             items, steps);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
